FILE: rtl/core/llgmn_pkg.sv
// Package: shared types, constants and lookup tables of the LLGMN classifier.
`default_nettype none
package llgmn_pkg;

  localparam int FEATURES = 15;
  localparam int PAIRS = 10;
  localparam int CHANNELS = 4;
  localparam logic signed [15:0] BIAS_ONE = 16'sd8192;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [17:0] mul_op_t;
  typedef logic signed [35:0] mul_res_t;

  // First channel of pairwise product p (pairs in order aa ab ac ad bb bc bd cc cd dd)
  function automatic logic [1:0] pair_a(input logic [3:0] p);
    logic [1:0] r;
    case (p)
      4'd0, 4'd1, 4'd2, 4'd3: r = 2'd0;
      4'd4, 4'd5, 4'd6:       r = 2'd1;
      4'd7, 4'd8:             r = 2'd2;
      default:                r = 2'd3;
    endcase
    return r;
  endfunction

  // Second channel of pairwise product p
  function automatic logic [1:0] pair_b(input logic [3:0] p);
    logic [1:0] r;
    case (p)
      4'd0:             r = 2'd0;
      4'd1, 4'd4:       r = 2'd1;
      4'd2, 4'd5, 4'd7: r = 2'd2;
      default:          r = 2'd3;
    endcase
    return r;
  endfunction

  // exp(-n) in Q1.16, zero past the table
  function automatic logic [16:0] int_exp(input logic [3:0] n);
    logic [16:0] r;
    case (n)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      4'd9:    r = 17'd8;
      4'd10:   r = 17'd3;
      4'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // exp(-f/16) in Q1.16
  function automatic logic [16:0] frac_exp(input logic [3:0] f);
    logic [16:0] r;
    case (f)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd61565;
      4'd2:    r = 17'd57835;
      4'd3:    r = 17'd54331;
      4'd4:    r = 17'd51039;
      4'd5:    r = 17'd47947;
      4'd6:    r = 17'd45042;
      4'd7:    r = 17'd42313;
      4'd8:    r = 17'd39750;
      4'd9:    r = 17'd37341;
      4'd10:   r = 17'd35079;
      4'd11:   r = 17'd32954;
      4'd12:   r = 17'd30957;
      4'd13:   r = 17'd29081;
      4'd14:   r = 17'd27319;
      default: r = 17'd25664;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/llgmn_mul.sv
// Shared signed 18x18 multiplier used by the feature, multiply-accumulate and exponential steps.
`default_nettype none
module llgmn_mul (
  input  wire llgmn_pkg::mul_op_t  a,
  input  wire llgmn_pkg::mul_op_t  b,
  output llgmn_pkg::mul_res_t      p
);

  // Form the full-width signed product
  assign p = a * b;

endmodule
`default_nettype wire

FILE: rtl/core/llgmn_weight_mem.sv
// Weight store: single write port, one registered read port.
`default_nettype none
module llgmn_weight_mem #(
  parameter int DEPTH = 120,
  parameter int AW    = 7
) (
  input  wire                    clk,
  input  wire                    we,
  input  wire [AW-1:0]           waddr,
  input  wire llgmn_pkg::sample_t wdata,
  input  wire [AW-1:0]           raddr,
  output llgmn_pkg::sample_t     rdata
);

  llgmn_pkg::sample_t mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/llgmn_posterior_classifier_top.sv
// Top level: sequencer around one shared multiplier for LLGMN inference.
`default_nettype none
// After reset the block clears its weight store, one entry per cycle, all
// 15*CLASSES*COMPONENTS entries (120 by default), and accepts no transaction
// until done. A classify transaction uses the single multiplier to form the
// ten pairwise features, then one multiply-accumulate per feature and unit,
// then one exponential per unit, followed by a one-bit-per-cycle divider for
// each class posterior; output stalls hold the transaction. Weight loads are
// written straight from idle.
// Results leave one per class in class order; the last carries best_class.
module llgmn_posterior_classifier_top #(
  parameter int CLASSES    = 4,
  parameter int COMPONENTS = 2
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         in_req_type,
  input  wire  [6:0]  in_weight_index,
  input  wire  [15:0] in_weight_value,
  input  wire  [15:0] in_chan_a,
  input  wire  [15:0] in_chan_b,
  input  wire  [15:0] in_chan_c,
  input  wire  [15:0] in_chan_d,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_class_index,
  output logic [15:0] out_posterior,
  output logic [1:0]  out_best_class,
  output logic        out_last
);

  localparam int FEATURES = llgmn_pkg::FEATURES;
  localparam int UNITS = CLASSES * COMPONENTS;
  localparam int DEPTH = FEATURES * UNITS;
  localparam int AW    = $clog2(DEPTH);
  localparam int UW    = $clog2(UNITS);
  localparam int CW    = $clog2(CLASSES);
  localparam int JW    = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int ZW    = 36;
  localparam int SW    = $clog2(COMPONENTS * 65536 + 1);
  localparam int TW    = $clog2(UNITS * 65536 + 1);
  localparam int NW    = TW + 17;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FEAT = 4'd2;
  localparam logic [3:0] S_MAC  = 4'd3;
  localparam logic [3:0] S_ERD  = 4'd4;
  localparam logic [3:0] S_EX   = 4'd5;
  localparam logic [3:0] S_EM   = 4'd6;
  localparam logic [3:0] S_DSET = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam logic [3:0] LAST_FEAT = 4'(FEATURES - 1);
  localparam logic [3:0] LAST_PAIR = 4'(llgmn_pkg::PAIRS - 1);

  logic [3:0] state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  llgmn_pkg::sample_t ch_r [llgmn_pkg::CHANNELS];
  llgmn_pkg::sample_t feat_r [FEATURES];
  logic [3:0] pidx_r, pidx_nxt;
  logic [3:0] iss_i_r, iss_i_nxt;
  logic [UW-1:0] iss_u_r, iss_u_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic iss_done_r, iss_done_nxt;
  logic pend_r, pend_nxt;
  logic [3:0] pi_r, pi_nxt;
  logic [UW-1:0] pu_r, pu_nxt;
  logic signed [ZW-1:0] acc_r, acc_nxt;
  logic signed [ZW-1:0] zmax_r, zmax_nxt;
  logic signed [ZW-1:0] zmem [UNITS];
  logic signed [ZW-1:0] zrd_r;
  logic z_we;
  logic signed [ZW-1:0] z_wval;
  logic [UW-1:0] eu_r, eu_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic [3:0] n_r, n_nxt, f_r, f_nxt;
  logic zero_r, zero_nxt;
  logic [SW-1:0] csum_r [CLASSES];
  logic csum_clr, csum_add;
  logic [16:0] e_val;
  logic [TW-1:0] total_r, total_nxt;
  logic [TW-1:0] rem_r, rem_nxt;
  logic [16:0] nlo_r, nlo_nxt, q_r, q_nxt;
  logic [4:0] dcnt_r, dcnt_nxt;
  logic [CW-1:0] best_r, best_nxt;
  logic [15:0] bestv_r, bestv_nxt;
  logic [1:0] oc_r, oc_nxt, ob_r, ob_nxt;
  logic [15:0] op_r, op_nxt;
  logic ol_r, ol_nxt;

  // Memory port
  logic mem_we;
  logic [AW-1:0] mem_waddr;
  llgmn_pkg::sample_t mem_wdata;
  llgmn_pkg::sample_t mem_rdata;

  // Shared multiplier operands
  llgmn_pkg::mul_op_t mul_a, mul_b;
  llgmn_pkg::mul_res_t mul_p;

  logic in_fire, load_ok, feat_we;
  logic signed [ZW-1:0] acc_sum, rnd, x_val;
  logic signed [15:0] feat_val;
  logic [NW-1:0] num;
  logic [TW:0] sh;
  logic [15:0] post;
  logic [31:0] idx_inc;

  llgmn_weight_mem #(.DEPTH(DEPTH), .AW(AW)) u_wmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  llgmn_mul u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_class_index = oc_r;
  assign out_posterior   = op_r;
  assign out_best_class  = ob_r;
  assign out_last        = ol_r;

  // Check a load index: inside the store and not on the last class-component
  always_comb begin
    idx_inc = {25'd0, in_weight_index} + 32'd1;
    load_ok = (idx_inc <= 32'(DEPTH));
    for (int f = 1; f <= FEATURES; f++) begin
      if (idx_inc == 32'(f * UNITS)) begin
        load_ok = 1'b0;
      end
    end
  end

  // Select multiplier operands by phase
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_FEAT: begin
        mul_a = 18'(ch_r[llgmn_pkg::pair_a(pidx_r)]);
        mul_b = 18'(ch_r[llgmn_pkg::pair_b(pidx_r)]);
      end
      S_MAC: begin
        mul_a = 18'(feat_r[pi_r]);
        mul_b = 18'(mem_rdata);
      end
      S_EM: begin
        mul_a = $signed({1'b0, llgmn_pkg::int_exp(n_r)});
        mul_b = $signed({1'b0, llgmn_pkg::frac_exp(f_r)});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Round a pairwise product to Q2.13 and saturate
  always_comb begin
    rnd = (mul_p + 36'sd4096) >>> 13;
    if (rnd > 36'sd32767) begin
      feat_val = 16'sd32767;
    end else if (rnd < -36'sd32768) begin
      feat_val = -16'sd32768;
    end else begin
      feat_val = rnd[15:0];
    end
  end

  assign acc_sum = ((pi_r == 4'd0) ? '0 : acc_r) + mul_p;
  assign x_val   = zmax_r - zrd_r;
  assign e_val   = zero_r ? 17'd0 : 17'((mul_p + 36'sd32768) >>> 16);
  assign num     = {(NW - SW - 16)'(0), csum_r[k_r], 16'd0} + NW'(total_r >> 1);
  assign sh      = {rem_r, nlo_r[16]};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    pidx_nxt = pidx_r;
    iss_i_nxt = iss_i_r;
    iss_u_nxt = iss_u_r;
    addr_nxt = addr_r;
    iss_done_nxt = iss_done_r;
    pend_nxt = 1'b0;
    pi_nxt = pi_r;
    pu_nxt = pu_r;
    acc_nxt = acc_r;
    zmax_nxt = zmax_r;
    z_we = 1'b0;
    z_wval = '0;
    eu_nxt = eu_r;
    k_nxt = k_r;
    j_nxt = j_r;
    n_nxt = n_r;
    f_nxt = f_r;
    zero_nxt = zero_r;
    csum_clr = 1'b0;
    csum_add = 1'b0;
    total_nxt = total_r;
    rem_nxt = rem_r;
    nlo_nxt = nlo_r;
    q_nxt = q_r;
    dcnt_nxt = dcnt_r;
    best_nxt = best_r;
    bestv_nxt = bestv_r;
    oc_nxt = oc_r;
    op_nxt = op_r;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    mem_we = 1'b0;
    mem_waddr = AW'(in_weight_index);
    mem_wdata = in_weight_value;
    feat_we = 1'b0;
    post = 16'd0;

    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (!in_req_type) begin
            mem_we = load_ok;
          end else begin
            pidx_nxt = '0;
            state_nxt = S_FEAT;
          end
        end
      end
      S_FEAT: begin
        feat_we = 1'b1;
        pidx_nxt = pidx_r + 1'b1;
        if (pidx_r == LAST_PAIR) begin
          iss_i_nxt = '0;
          iss_u_nxt = '0;
          addr_nxt = '0;
          iss_done_nxt = 1'b0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        // Issue one weight read per cycle
        if (!iss_done_r) begin
          pend_nxt = 1'b1;
          pi_nxt = iss_i_r;
          pu_nxt = iss_u_r;
          if (iss_i_r == LAST_FEAT) begin
            iss_i_nxt = '0;
            addr_nxt = AW'(iss_u_r) + 1'b1;
            if (iss_u_r == UW'(UNITS - 1)) begin
              iss_done_nxt = 1'b1;
            end else begin
              iss_u_nxt = iss_u_r + 1'b1;
            end
          end else begin
            iss_i_nxt = iss_i_r + 1'b1;
            addr_nxt = addr_r + AW'(UNITS);
          end
        end
        // Accumulate the returned weight
        if (pend_r) begin
          acc_nxt = acc_sum;
          if (pi_r == LAST_FEAT) begin
            z_we = 1'b1;
            z_wval = (pu_r == UW'(UNITS - 1)) ? '0 : acc_sum;
            if (pu_r == '0 || z_wval > zmax_r) begin
              zmax_nxt = z_wval;
            end
            if (pu_r == UW'(UNITS - 1)) begin
              eu_nxt = '0;
              k_nxt = '0;
              j_nxt = '0;
              csum_clr = 1'b1;
              total_nxt = '0;
              state_nxt = S_ERD;
            end
          end
        end
      end
      S_ERD: begin
        state_nxt = S_EX;
      end
      S_EX: begin
        zero_nxt = (x_val >= 36'sd201326592);
        n_nxt = x_val[27:24];
        f_nxt = x_val[23:20];
        state_nxt = S_EM;
      end
      S_EM: begin
        csum_add = 1'b1;
        total_nxt = total_r + TW'(e_val);
        if (eu_r == UW'(UNITS - 1)) begin
          k_nxt = '0;
          state_nxt = S_DSET;
        end else begin
          eu_nxt = eu_r + 1'b1;
          if (j_r == JW'(COMPONENTS - 1)) begin
            j_nxt = '0;
            k_nxt = k_r + 1'b1;
          end else begin
            j_nxt = j_r + 1'b1;
          end
          state_nxt = S_ERD;
        end
      end
      S_DSET: begin
        rem_nxt = TW'(num >> 17);
        nlo_nxt = num[16:0];
        q_nxt = '0;
        dcnt_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // One restoring step per cycle
        nlo_nxt = {nlo_r[15:0], 1'b0};
        if (sh >= {1'b0, total_r}) begin
          rem_nxt = TW'(sh - {1'b0, total_r});
          q_nxt = {q_r[15:0], 1'b1};
        end else begin
          rem_nxt = sh[TW-1:0];
          q_nxt = {q_r[15:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 5'd16) begin
          post = q_nxt[16] ? 16'hFFFF : q_nxt[15:0];
          if (k_r == '0 || post > bestv_r) begin
            bestv_nxt = post;
            best_nxt = k_r;
          end
          oc_nxt = 2'(k_r);
          op_nxt = post;
          ol_nxt = (k_r == CW'(CLASSES - 1));
          ob_nxt = ol_nxt ? 2'(best_nxt) : 2'd0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (ol_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
            state_nxt = S_DSET;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pidx_r <= pidx_nxt;
    iss_i_r <= iss_i_nxt;
    iss_u_r <= iss_u_nxt;
    addr_r <= addr_nxt;
    iss_done_r <= iss_done_nxt;
    pi_r <= pi_nxt;
    pu_r <= pu_nxt;
    acc_r <= acc_nxt;
    zmax_r <= zmax_nxt;
    eu_r <= eu_nxt;
    k_r <= k_nxt;
    j_r <= j_nxt;
    n_r <= n_nxt;
    f_r <= f_nxt;
    zero_r <= zero_nxt;
    total_r <= total_nxt;
    rem_r <= rem_nxt;
    nlo_r <= nlo_nxt;
    q_r <= q_nxt;
    dcnt_r <= dcnt_nxt;
    best_r <= best_nxt;
    bestv_r <= bestv_nxt;
    oc_r <= oc_nxt;
    op_r <= op_nxt;
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
  end

  // Capture samples and features
  always_ff @(posedge clk) begin
    if (in_fire && in_req_type) begin
      ch_r[0] <= in_chan_a;
      ch_r[1] <= in_chan_b;
      ch_r[2] <= in_chan_c;
      ch_r[3] <= in_chan_d;
      feat_r[0] <= llgmn_pkg::BIAS_ONE;
      feat_r[1] <= in_chan_a;
      feat_r[2] <= in_chan_b;
      feat_r[3] <= in_chan_c;
      feat_r[4] <= in_chan_d;
    end
    if (feat_we) begin
      feat_r[4'(pidx_r + 4'd5)] <= feat_val;
    end
  end

  // Logit memory: written once per unit, read registered
  always_ff @(posedge clk) begin
    if (z_we) begin
      zmem[pu_r] <= z_wval;
    end
    zrd_r <= zmem[eu_r];
  end

  // Per-class exponential sums
  always_ff @(posedge clk) begin
    for (int c = 0; c < CLASSES; c++) begin
      if (csum_clr) begin
        csum_r[c] <= '0;
      end else if (csum_add && k_r == CW'(c)) begin
        csum_r[c] <= csum_r[c] + SW'(e_val);
      end
    end
  end

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench for the LLGMN posterior classifier: weight loads, classify requests, result checks.
`timescale 1ns / 1ps
module tb;

  localparam int NCLS = 4;
  localparam int NCMP = 2;
  localparam int NUNIT = NCLS * NCMP;
  localparam int NWGT = llgmn_pkg::FEATURES * NUNIT;
  localparam int TIMEOUT_CYCLES = 600000;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  typedef struct packed {
    logic        req;
    logic [6:0]  idx;
    logic [15:0] wval;
    logic [15:0] a, b, c, d;
  } request_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic [15:0] post;
    logic [1:0]  best;
    logic        last;
  } posterior_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_ready_s = 1'b0;
  logic in_req_type = 1'b0;
  logic [6:0] in_weight_index = '0;
  logic [15:0] in_weight_value = '0;
  logic [15:0] in_chan_a = '0, in_chan_b = '0, in_chan_c = '0, in_chan_d = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_class_index;
  logic [15:0] out_posterior;
  logic [1:0] out_best_class;
  logic out_last;

  request_t pending_reqs[$];
  posterior_t expected_posts[$];
  logic signed [15:0] weights[NWGT] = '{default: 16'sd0};
  int errors = 0;
  int n_loads = 0, n_classify = 0, n_results = 0;
  int cycles = 0;
  bit stim_done = 0;
  int burst_left = 0, gap_left = 0;
  int stall_phase = 0;

  llgmn_posterior_classifier_top dut (.*);

  // Generate the clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [15:0] round_product(logic signed [15:0] x,
                                                      logic signed [15:0] y);
    logic signed [63:0] p;
    p = (64'(x) * 64'(y) + 64'sd4096) >>> 13;
    if (p > 64'sd32767) return 16'sd32767;
    if (p < -64'sd32768) return -16'sd32768;
    return p[15:0];
  endfunction

  function automatic logic [31:0] lookup_exp(logic [63:0] x);
    logic [63:0] t;
    logic [63:0] prod;
    t = x >> 20;
    if ((t >> 4) >= 12) return 32'd0;
    prod = 64'(llgmn_pkg::int_exp(t[7:4])) * 64'(llgmn_pkg::frac_exp(t[3:0])) + 64'd32768;
    return 32'(prod >> 16);
  endfunction

  // Apply one request to the weight copy and queue the posteriors it yields
  task automatic predict_posteriors(request_t r);
    logic signed [15:0] feat[llgmn_pkg::FEATURES];
    logic signed [15:0] ch[4];
    logic signed [63:0] z[NUNIT];
    logic signed [63:0] zmax;
    logic [31:0] csum[NCLS];
    logic [31:0] total;
    logic [63:0] p;
    logic [31:0] post[NCLS];
    logic [31:0] best_val;
    int best, k;
    posterior_t e;
    if (r.req == REQ_LOAD) begin
      if (r.idx < NWGT && (r.idx % NUNIT) != NUNIT - 1) weights[r.idx] = r.wval;
      return;
    end
    ch[0] = r.a; ch[1] = r.b; ch[2] = r.c; ch[3] = r.d;
    feat[0] = llgmn_pkg::BIAS_ONE;
    for (int i = 0; i < 4; i++) feat[1 + i] = ch[i];
    k = 5;
    for (int i = 0; i < 4; i++)
      for (int j = i; j < 4; j++) begin
        feat[k] = round_product(ch[i], ch[j]);
        k++;
      end
    for (int u = 0; u < NUNIT; u++) begin
      z[u] = 0;
      for (int i = 0; i < llgmn_pkg::FEATURES; i++)
        z[u] += 64'(feat[i]) * 64'(weights[i * NUNIT + u]);
      if (u == NUNIT - 1) z[u] = 0;
    end
    zmax = z[0];
    for (int u = 1; u < NUNIT; u++) if (z[u] > zmax) zmax = z[u];
    total = 0;
    for (int c = 0; c < NCLS; c++) begin
      csum[c] = 0;
      for (int j = 0; j < NCMP; j++) csum[c] += lookup_exp(64'(zmax - z[c * NCMP + j]));
      total += csum[c];
    end
    best = 0;
    best_val = 0;
    for (int c = 0; c < NCLS; c++) begin
      p = (64'(csum[c]) * 64'd65536 + 64'(total / 2)) / 64'(total);
      if (p > 64'd65535) p = 64'd65535;
      post[c] = p[31:0];
      if (c == 0 || post[c] > best_val) begin
        best_val = post[c];
        best = c;
      end
    end
    for (int c = 0; c < NCLS; c++) begin
      e.cls = 2'(c);
      e.post = post[c][15:0];
      e.last = (c == NCLS - 1);
      e.best = e.last ? 2'(best) : 2'd0;
      expected_posts.push_back(e);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4, 5: return 16'($signed($urandom_range(0, 16384)) - 8192);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic request_t load_req(int idx, logic [15:0] v);
    request_t r;
    r = '0;
    r.req = REQ_LOAD;
    r.idx = 7'(idx);
    r.wval = v;
    r.a = 16'($urandom);
    return r;
  endfunction

  function automatic request_t classify_req(logic [15:0] a, logic [15:0] b,
                                            logic [15:0] c, logic [15:0] d);
    request_t r;
    r.req = REQ_CLASSIFY;
    r.idx = 7'($urandom);
    r.wval = 16'($urandom);
    r.a = a; r.b = b; r.c = c; r.d = d;
    return r;
  endfunction

  // Fill the request queue: directed cases first, then random mixes
  initial begin
    logic [15:0] v;
    int idx;
    // all-zero weights: even posteriors
    pending_reqs.push_back(classify_req(16'h7FFF, 16'h8000, 16'h0000, 16'h2000));
    // one class dominates through a big bias weight: saturated posterior
    pending_reqs.push_back(load_req(2, 16'h7FFF));
    pending_reqs.push_back(classify_req(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // loads to the last component are ignored, out-of-range indexes too
    pending_reqs.push_back(load_req(7, 16'h7FFF));
    pending_reqs.push_back(load_req(119, 16'h8000));
    pending_reqs.push_back(load_req(120, 16'h7FFF));
    pending_reqs.push_back(load_req(127, 16'h8000));
    pending_reqs.push_back(classify_req(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    // negative extreme weights on product features
    pending_reqs.push_back(load_req(118, 16'h8000));
    pending_reqs.push_back(load_req(40, 16'h8000));
    pending_reqs.push_back(load_req(0, 16'h1234));
    pending_reqs.push_back(classify_req(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    pending_reqs.push_back(classify_req(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF));
    pending_reqs.push_back(load_req(2, 16'h0000));
    pending_reqs.push_back(classify_req(16'h2000, 16'hE000, 16'h1000, 16'hF000));
    // random part: weight bursts then classifications
    while (pending_reqs.size() < 220) begin
      repeat ($urandom_range(0, 6)) begin
        idx = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 119);
        case ($urandom_range(0, 5))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2, 3: v = 16'($signed($urandom_range(0, 8192)) - 4096);
          default: v = 16'($urandom);
        endcase
        pending_reqs.push_back(load_req(idx, v));
      end
      repeat ($urandom_range(1, 3))
        pending_reqs.push_back(classify_req(pick_sample(), pick_sample(),
                                            pick_sample(), pick_sample()));
    end
  end

  // Reset, then wait for the queue to drain and the results to land
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (pending_reqs.size() == 0 && stim_done);
    wait (expected_posts.size() == 0);
    repeat (300) @(posedge clk);
    $display("covered %0d weight loads and %0d classify requests, %0d posteriors checked",
             n_loads, n_classify, n_results);
    if (errors == 0 && expected_posts.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("timeout with %0d results outstanding", expected_posts.size());
      $display("status: fail");
      $finish;
    end
  end

  // Driver: hold the transaction until accepted, send in bursts with gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_s) begin
        predict_posteriors({in_req_type, in_weight_index, in_weight_value,
                            in_chan_a, in_chan_b, in_chan_c, in_chan_d});
        if (in_req_type == REQ_LOAD) n_loads++;
        else n_classify++;
      end
      if (!in_valid || in_ready_s) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          request_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          {in_req_type, in_weight_index, in_weight_value,
           in_chan_a, in_chan_b, in_chan_c, in_chan_d} <= r;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
          stim_done = 1;
        end
      end
    end
  end

  // Capture the handshake at the rising edge for the driver
  always @(posedge clk) in_ready_s <= in_valid && in_ready;

  // Receiver stall pattern: long ready stretches, then spells of random stalls
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 400;
    if (stall_phase < 150) out_ready <= 1'b1;
    else if (stall_phase < 250) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 1) == 0);
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      posterior_t e;
      n_results++;
      if (expected_posts.size() == 0) begin
        report_mismatch("unexpected result, class_index", out_class_index, -1);
      end else begin
        e = expected_posts.pop_front();
        if (out_class_index !== e.cls) report_mismatch("class_index", out_class_index, e.cls);
        if (out_posterior !== e.post) report_mismatch("posterior", out_posterior, e.post);
        if (out_best_class !== e.best) report_mismatch("best_class", out_best_class, e.best);
        if (out_last !== e.last) report_mismatch("last", out_last, e.last);
      end
    end
  end

endmodule
